// ===== rtl/core/utf16_bmp_to_utf8_encoder_macros.svh =====
// assertion macros for the utf16 to utf8 encoder checker
// no dependencies; included by the checker file
`ifndef UTF16_BMP_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_BMP_TO_UTF8_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define U2U_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u2u assertion failed");

// next-cycle implication, disabled during reset
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u2u assertion failed");

`endif

// ===== rtl/core/u2u_pkg.sv =====
// shared types and constants of the utf16 to utf8 encoder
// no dependencies; used by every module of the block
package u2u_pkg;

  localparam int MAX_OUT_BYTES_DEF = 4096;

  // job queue depth, a power of two
  localparam int QUEUE_DEPTH = 4;

  localparam logic [12:0] OUT_SIZE_RESET = 13'd128;

  // register byte addresses
  localparam logic [2:0] ADDR_OUT_SIZE = 3'd0;
  localparam logic [2:0] ADDR_NEWLINE  = 3'd4;

  localparam logic [15:0] LIMIT_ONE = 16'h0080;
  localparam logic [15:0] LIMIT_TWO = 16'h0800;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [5:0]  CONT_MASK  = 6'h3F;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_t;

  typedef struct packed {
    logic [12:0] out_size;
    logic        newline_to_space;
  } cfg_t;

  // work for the back end: up to three data bytes, then an optional nul
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            term;
  } job_t;

endpackage

// ===== rtl/core/u2u_queue.sv =====
// short job queue between the front and back ends
// depends on u2u_pkg
module u2u_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  u2u_pkg::job_t   wr_job,
  output logic            full,
  input  logic            rd,
  output u2u_pkg::job_t   head,
  output logic            empty
);

  localparam int PW = $clog2(u2u_pkg::QUEUE_DEPTH);
  localparam int CNTW = PW + 1;

  u2u_pkg::job_t mem [u2u_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full  = (count == CNTW'(u2u_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(u2u_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(u2u_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/u2u_front.sv =====
// front end: accepts code units, tracks string state, builds byte jobs
// depends on u2u_pkg
module u2u_front #(
  parameter int MAX_OUT_BYTES = u2u_pkg::MAX_OUT_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  u2u_pkg::in_t    item,
  input  u2u_pkg::cfg_t   cfg,
  output logic            job_wr,
  output u2u_pkg::job_t   job
);

  localparam int BW  = $clog2(MAX_OUT_BYTES);
  localparam int CW0 = $clog2(MAX_OUT_BYTES) + 2;
  localparam int CW  = (CW0 > 14) ? CW0 : 14;

  logic [BW-1:0] bytes_written;
  logic [BW-1:0] bytes_written_next;
  logic          string_closed;
  logic          string_closed_next;

  logic [CW-1:0] size;
  logic [CW-1:0] osz;
  logic [1:0]    need;
  logic [CW-1:0] sum;
  logic          overflow;
  logic [15:0]   cu;
  logic [7:0]    low_byte;

  assign cu  = item.code_unit;
  assign osz = CW'(cfg.out_size);

  always_comb begin
    if (osz == '0) begin
      size = CW'(1);
    end else if (osz > CW'(MAX_OUT_BYTES)) begin
      size = CW'(MAX_OUT_BYTES);
    end else begin
      size = osz;
    end
    if (cu < u2u_pkg::LIMIT_ONE) begin
      need = 2'd1;
    end else if (cu < u2u_pkg::LIMIT_TWO) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    sum      = CW'(bytes_written) + CW'(need);
    overflow = (cu == '0) || (sum >= size);
    low_byte = cu[7:0];
    if (cfg.newline_to_space &&
        (low_byte == u2u_pkg::CHAR_LF || low_byte == u2u_pkg::CHAR_CR)) begin
      low_byte = u2u_pkg::CHAR_SPACE;
    end
  end

  always_comb begin
    job                = '0;
    job_wr             = 1'b0;
    bytes_written_next = bytes_written;
    string_closed_next = string_closed;
    if (string_closed) begin
      if (item.last_unit) begin
        bytes_written_next = '0;
        string_closed_next = 1'b0;
      end
    end else begin
      job_wr = 1'b1;
      if (overflow) begin
        job.term = 1'b1;
        if (item.last_unit) begin
          bytes_written_next = '0;
        end else begin
          string_closed_next = 1'b1;
        end
      end else begin
        job.nbytes = need;
        job.term   = item.last_unit;
        unique case (need)
          2'd1: begin
            job.data[0] = low_byte;
          end
          2'd2: begin
            job.data[0] = u2u_pkg::LEAD_TWO | 8'(cu[10:6]);
            job.data[1] = u2u_pkg::CONT_MARK | 8'(cu[5:0] & u2u_pkg::CONT_MASK);
          end
          default: begin
            job.data[0] = u2u_pkg::LEAD_THREE | 8'(cu[15:12]);
            job.data[1] = u2u_pkg::CONT_MARK | 8'(cu[11:6] & u2u_pkg::CONT_MASK);
            job.data[2] = u2u_pkg::CONT_MARK | 8'(cu[5:0] & u2u_pkg::CONT_MASK);
          end
        endcase
        bytes_written_next = item.last_unit ? '0 : BW'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
      string_closed <= 1'b0;
    end else if (accept) begin
      bytes_written <= bytes_written_next;
      string_closed <= string_closed_next;
    end
  end

endmodule

// ===== rtl/core/u2u_back.sv =====
// back end: walks the head job byte by byte into the output register
// depends on u2u_pkg
module u2u_back (
  input  logic            clk,
  input  logic            rst,
  input  u2u_pkg::job_t   head,
  input  logic            q_empty,
  output logic            q_rd,
  output u2u_pkg::out_t   result,
  output logic            empty,
  input  logic            pop
);

  logic [1:0]    idx;
  logic          out_valid;
  u2u_pkg::out_t out_reg;
  logic          load_ok;
  logic          emit;
  logic [2:0]    total;
  logic          job_done;
  u2u_pkg::out_t next_out;

  assign load_ok  = !out_valid || pop;
  assign emit     = !q_empty && load_ok;
  assign total    = 3'(head.nbytes) + 3'(head.term);
  assign job_done = ({1'b0, idx} == total - 3'd1);
  assign q_rd     = emit && job_done;
  assign result   = out_reg;
  assign empty    = !out_valid;

  always_comb begin
    next_out = '0;
    if (idx < head.nbytes) begin
      case (idx)
        2'd0:    next_out.out_byte = head.data[0];
        2'd1:    next_out.out_byte = head.data[1];
        default: next_out.out_byte = head.data[2];
      endcase
    end else begin
      next_out.is_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= next_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx <= job_done ? 2'd0 : idx + 2'd1;
      end
      if (load_ok) begin
        out_valid <= emit;
      end
    end
  end

endmodule

// ===== rtl/core/utf16_bmp_to_utf8_encoder.sv =====
// top level of the utf16 (bmp) to utf8 encoder with its apb register port
// depends on u2u_pkg, u2u_front, u2u_queue and u2u_back
//
// usage:
//   input channel: one utf16 code unit per transaction (push/full). a unit
//   flagged last_unit closes the string with a nul marked is_last.
//   result channel: one utf8 byte per transaction (empty/pop); the string
//   ends with a nul byte carrying is_last, also on early close by a zero
//   unit or by a character that no longer fits in out_size bytes.
//   registers: out_size at byte address 0, newline_to_space at address 4;
//   the user must write them only while the block is idle (not enforced).
// path: a unit's job goes through the job queue into the result register.
// throughput: while pop is high the result register moves one byte per cycle;
//   a unit of an open string yields one to four bytes (its byte count plus a
//   possible nul); the input side takes a unit every cycle while the
//   four-entry job queue has room.
// reset: string state, queue and result register clear, registers return
//   to out_size 128 and newline_to_space 0.
// stall: when pop stays low the result holds, the queue fills and full
//   rises; no transaction is lost.
module utf16_bmp_to_utf8_encoder #(
  parameter int MAX_OUT_BYTES = u2u_pkg::MAX_OUT_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // input channel
  input  logic          push,
  output logic          full,
  input  u2u_pkg::in_t  item,
  // result channel
  output logic          empty,
  input  logic          pop,
  output u2u_pkg::out_t result,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  u2u_pkg::cfg_t cfg;
  u2u_pkg::job_t job;
  u2u_pkg::job_t head;
  logic          accept;
  logic          job_wr;
  logic          q_full;
  logic          q_empty;
  logic          q_rd;
  logic          reg_wr;

  // register port: always ready, word-aligned decode on paddr bit 2
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_size         <= u2u_pkg::OUT_SIZE_RESET;
      cfg.newline_to_space <= 1'b0;
    end else if (reg_wr) begin
      if (paddr[2] == u2u_pkg::ADDR_NEWLINE[2]) begin
        cfg.newline_to_space <= pwdata[0];
      end else begin
        cfg.out_size <= pwdata[12:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == u2u_pkg::ADDR_OUT_SIZE[2]) begin
      prdata = 32'(cfg.out_size);
    end else begin
      prdata = 32'(cfg.newline_to_space);
    end
  end

  // every accepted unit updates the string state; only units of an open
  // string push a job
  assign full   = q_full;
  assign accept = push && !q_full;

  u2u_front #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .job_wr (job_wr),
    .job    (job)
  );

  // decouples unit intake from byte output
  u2u_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept && job_wr),
    .wr_job (job),
    .full   (q_full),
    .rd     (q_rd),
    .head   (head),
    .empty  (q_empty)
  );

  // byte sequencer and result register
  u2u_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ===== rtl/core/u2u_checker.sv =====
// port-level checks of the utf16 to utf8 encoder, bound to the top level
// depends on u2u_pkg and utf16_bmp_to_utf8_encoder_macros.svh
`include "utf16_bmp_to_utf8_encoder_macros.svh"

module u2u_checker (
  input logic          clk,
  input logic          rst,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input u2u_pkg::out_t result
);

  // a waiting result holds until popped
  `U2U_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result))

  // the terminator is always a nul byte
  `U2U_ASSERT_NOW(a_term_nul, clk, rst, !empty && result.is_last, result.out_byte == 8'h00)

  // nothing is waiting right after reset
  `U2U_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), empty)

  // the queue is open right after reset
  `U2U_ASSERT_NOW(a_reset_room, clk, rst, $past(rst), !full)

endmodule

bind utf16_bmp_to_utf8_encoder u2u_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== dv/utf16_bmp_to_utf8_encoder_checker.sv =====
// checker for the utf16 to utf8 encoder: watches input, result and register port,
// predicts the utf8 byte stream and compares it field by field against the block
// depends on u2u_pkg
module utf16_bmp_to_utf8_encoder_checker #(
  parameter int MAX_OUT_BYTES = u2u_pkg::MAX_OUT_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          full,
  input  u2u_pkg::in_t  item,
  input  logic          empty,
  input  logic          pop,
  input  u2u_pkg::out_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output int unsigned   bytes_pending,
  output int unsigned   fail_count
);
  import u2u_pkg::*;

  logic [12:0] size_reg;
  logic        nl_map;
  int          written;
  logic        closed;
  out_t        utf8_queue[$];

  function automatic void queue_byte(logic [7:0] b, logic l);
    out_t r;
    r.out_byte = b;
    r.is_last  = l;
    utf8_queue.push_back(r);
  endfunction

  // encode one code unit against the current string state
  function automatic void encode_unit(in_t u);
    int          lim;
    int          need;
    logic [15:0] cu;
    logic [7:0]  b;
    cu = u.code_unit;
    if (closed) begin
      if (u.last_unit) begin
        written = 0;
        closed  = 1'b0;
      end
      return;
    end
    lim = int'(size_reg);
    if (lim < 1) lim = 1;
    if (lim > MAX_OUT_BYTES) lim = MAX_OUT_BYTES;
    need = (cu < LIMIT_ONE) ? 1 : (cu < LIMIT_TWO) ? 2 : 3;
    if (cu == 16'h0000 || written + need >= lim) begin
      queue_byte(8'h00, 1'b1);
      if (u.last_unit) written = 0;
      else closed = 1'b1;
      return;
    end
    case (need)
      1: begin
        b = cu[7:0];
        if (nl_map && (b == CHAR_LF || b == CHAR_CR)) b = CHAR_SPACE;
        queue_byte(b, 1'b0);
      end
      2: begin
        queue_byte(LEAD_TWO | {3'b000, cu[10:6]}, 1'b0);
        queue_byte(CONT_MARK | {2'b00, cu[5:0] & CONT_MASK}, 1'b0);
      end
      default: begin
        queue_byte(LEAD_THREE | {4'b0000, cu[15:12]}, 1'b0);
        queue_byte(CONT_MARK | {2'b00, cu[11:6]}, 1'b0);
        queue_byte(CONT_MARK | {2'b00, cu[5:0] & CONT_MASK}, 1'b0);
      end
    endcase
    written = written + need;
    if (u.last_unit) begin
      queue_byte(8'h00, 1'b1);
      written = 0;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      size_reg   = OUT_SIZE_RESET;
      nl_map     = 1'b0;
      written    = 0;
      closed     = 1'b0;
      fail_count = 0;
      utf8_queue.delete();
    end else begin
      // results first: a byte can never belong to a unit taken at this same edge
      if (!empty && pop) begin
        if (utf8_queue.size() == 0) begin
          $error("unexpected result transaction: out_byte %h is_last %b",
                 result.out_byte, result.is_last);
          fail_count++;
        end else begin
          want = utf8_queue.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, result.out_byte);
            fail_count++;
          end
          if (result.is_last !== want.is_last) begin
            $error("is_last expected %b actual %b", want.is_last, result.is_last);
            fail_count++;
          end
        end
      end
      if (push && !full) encode_unit(item);
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_OUT_SIZE) size_reg = pwdata[12:0];
        else if (paddr == ADDR_NEWLINE) nl_map = pwdata[0];
      end
    end
    bytes_pending = utf8_queue.size();
  end

endmodule

// ===== dv/tb_utf16_bmp_to_utf8_encoder.sv =====
// top of the utf16 to utf8 encoder testbench: clock, reset, stimulus and verdict
// depends on u2u_pkg, utf16_bmp_to_utf8_encoder and utf16_bmp_to_utf8_encoder_checker
module tb_utf16_bmp_to_utf8_encoder;
  import u2u_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT = 1500;
  // length of the long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 60;
  // settle time after the last expected byte, covers units that emit nothing
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_t         item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned bytes_pending;
  int unsigned fail_count;

  // receiver controls, set by the stimulus process
  bit hold_results = 1'b0;
  bit no_idle = 1'b0;

  int idle_cycles = 0;

  always #2 clk = ~clk;

  utf16_bmp_to_utf8_encoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  utf16_bmp_to_utf8_encoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .bytes_pending (bytes_pending),
    .fail_count    (fail_count)
  );

  // hang watchdog: any accepted transaction or register write resets the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: short random stalls, one long hold-off on request, none at the end
  initial begin
    forever begin
      @(negedge clk);
      if (hold_results) begin
        // long hold-off so the job queue fills and full rises
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else if (no_idle || $urandom_range(0, 4) != 0) begin
        pop = 1'b1;
      end else begin
        pop = 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end
    end
  end

  // one input transaction; called at a falling edge, returns at the falling edge
  // after acceptance with push still high so back-to-back units need no gap
  task automatic send_unit(input logic [15:0] cu, input logic lu);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push = 1'b1;
    item.code_unit = cu;
    item.last_unit = lu;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait until every predicted byte has been popped,
  // then give units that emit nothing time to leave the pipeline
  task automatic drain_block();
    push = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // code unit mix weighted toward each encoding length, newlines and surrogates
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'h007F));
      1, 2:    return 16'($urandom_range(16'h0020, 16'h007E));
      3:       return ($urandom_range(0, 1) == 0) ? 16'h000A : 16'h000D;
      4, 5:    return 16'($urandom_range(16'h0080, 16'h07FF));
      6, 7:    return 16'($urandom_range(16'h0800, 16'hFFFF));
      8:       return 16'($urandom_range(16'hD800, 16'hDFFF));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // mostly whole strings ending on last_unit, some loose noise units
  task automatic send_strings(input int units);
    int sent;
    int len;
    sent = 0;
    while (sent < units) begin
      if ($urandom_range(0, 7) == 0) begin
        send_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_unit(pick_unit(), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    int sizes[7];
    sizes = '{5, 16, 2, 40, 4096, 1, 0};
    sizes[6] = $urandom_range(3, 64);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: encoding boundaries and newline mapping with room to spare
    write_reg(ADDR_OUT_SIZE, 32'd128);
    write_reg(ADDR_NEWLINE, 32'd1);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h000A, 1'b0);
    send_unit(16'h000D, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0020, 1'b1);
    // zero unit closes early, following units skipped until last_unit re-arms
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);
    // zero unit that is also the last one re-arms at once
    send_unit(16'h0000, 1'b1);
    drain_block();

    // newlines pass through unchanged with mapping off
    write_reg(ADDR_NEWLINE, 32'd0);
    send_unit(16'h000A, 1'b0);
    send_unit(16'h000D, 1'b1);
    drain_block();

    // size zero acts as one: only the terminator fits
    write_reg(ADDR_OUT_SIZE, 32'd0);
    send_unit(16'h0041, 1'b1);
    drain_block();

    // oversized value saturates at the maximum buffer size
    write_reg(ADDR_OUT_SIZE, 32'h0000_1FFF);
    send_unit(16'hFFFF, 1'b1);
    drain_block();

    // overflow: fourth ascii byte no longer fits in four bytes with the nul
    write_reg(ADDR_OUT_SIZE, 32'd4);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b0);
    send_unit(16'h0044, 1'b0);
    send_unit(16'h0045, 1'b1);
    drain_block();

    // three-byte character that overflows on a unit flagged last
    write_reg(ADDR_OUT_SIZE, 32'd3);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'h00E9, 1'b1);
    drain_block();

    // random phases; strings may stay open across a size change
    for (int p = 0; p < 7; p++) begin
      write_reg(ADDR_OUT_SIZE, sizes[p]);
      write_reg(ADDR_NEWLINE, 32'($urandom_range(0, 1)));
      if (p == 1) hold_results = 1'b1;
      if (p == 6) no_idle = 1'b1;
      send_strings(37);
      // sender pauses here until every predicted byte has been taken
      drain_block();
    end

    if (fail_count == 0 && bytes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/u2u_pkg.sv
rtl/core/u2u_queue.sv
rtl/core/u2u_front.sv
rtl/core/u2u_back.sv
rtl/core/utf16_bmp_to_utf8_encoder.sv
rtl/core/u2u_checker.sv
dv/utf16_bmp_to_utf8_encoder_checker.sv
dv/tb_utf16_bmp_to_utf8_encoder.sv
